// ----- rtl/efra_pkg.sv -----
// Package: microcode word, datapath op and branch codes, step table of the room assigner.
package efra_pkg;

	localparam int START_W = 20;
	localparam int TIME_W  = 48;
	localparam int ROOM_W  = 7;
	localparam int CFG_W   = 8;
	localparam int STEP_W  = 4;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_SCAN,
		OP_PICK,
		OP_INC,
		OP_BSCAN,
		OP_CLEAR,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_SCAN_MORE,
		C_NOT_LAST,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic scan_more;
		logic last;
		logic out_busy;
	} stat_t;

	localparam step_t S_IDLE  = 4'd0;
	localparam step_t S_SCAN  = 4'd1;
	localparam step_t S_STAIL = 4'd2;
	localparam step_t S_PICK  = 4'd3;
	localparam step_t S_INC   = 4'd4;
	localparam step_t S_BSCAN = 4'd5;
	localparam step_t S_BTAIL = 4'd6;
	localparam step_t S_CLEAR = 4'd7;
	localparam step_t S_EMIT  = 4'd8;
	localparam step_t S_RET   = 4'd9;

	// Program ROM: jump to target when cond holds, else fall through.
	function automatic uword_t ucode(step_t s);
		uword_t w;
		case (s)
			S_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_IN,     target: S_IDLE};
			S_SCAN:  w = '{op: OP_SCAN,  cond: C_SCAN_MORE, target: S_SCAN};
			S_STAIL: w = '{op: OP_NOP,   cond: C_NEVER,     target: S_IDLE};
			S_PICK:  w = '{op: OP_PICK,  cond: C_NEVER,     target: S_IDLE};
			S_INC:   w = '{op: OP_INC,   cond: C_NOT_LAST,  target: S_EMIT};
			S_BSCAN: w = '{op: OP_BSCAN, cond: C_SCAN_MORE, target: S_BSCAN};
			S_BTAIL: w = '{op: OP_NOP,   cond: C_NEVER,     target: S_IDLE};
			S_CLEAR: w = '{op: OP_CLEAR, cond: C_NEVER,     target: S_IDLE};
			S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: S_EMIT};
			S_RET:   w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_IDLE};
			default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/efra_seq.sv -----
// Microcode sequencer: step counter, program ROM lookup and conditional branch.
module efra_seq
	import efra_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stat_t  stat,
	output uword_t uw
);

	step_t step_q;
	step_t step_d;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		uw = ucode(step_q);
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_IN:     take = !stat.in_valid;
			C_SCAN_MORE: take = stat.scan_more;
			C_NOT_LAST:  take = !stat.last;
			C_OUT_BUSY:  take = stat.out_busy;
			default:     take = 1'b1;
		endcase
		step_d = take ? uw.target : step_q + step_t'(1);
	end

endmodule

// ----- rtl/efra_dp.sv -----
// Datapath: room memories, scan compare units, finish-time and count update.
module efra_dp
	import efra_pkg::*;
#(
	parameter int ROOMS      = 16,
	parameter int COUNT_BITS = 16,
	parameter int IDX_W      = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  uword_t             uw,
	input  logic               in_take,
	input  logic [START_W-1:0] start_time,
	input  logic [START_W-1:0] end_time,
	input  logic               last_meeting,
	input  logic [IDX_W-1:0]   last_idx,
	output logic               scan_more,
	output logic               last_flag,
	output logic [ROOM_W-1:0]  assigned_room,
	output logic               was_delayed,
	output logic [TIME_W-1:0]  finish_time,
	output logic [ROOM_W-1:0]  most_booked_room
);

	logic [TIME_W-1:0]     ft_mem [ROOMS];
	logic [COUNT_BITS-1:0] cnt_mem [ROOMS];
	logic [ROOMS-1:0]      ft_vld_q;
	logic [ROOMS-1:0]      cnt_vld_q;

	logic [START_W-1:0]    start_q;
	logic [START_W-1:0]    end_q;
	logic                  last_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      rdidx_q;
	logic                  rd_ft_q;
	logic                  rd_cnt_q;
	logic [TIME_W-1:0]     ft_rd_q;
	logic                  ft_rv_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic                  cnt_rv_q;
	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [IDX_W-1:0]      earl_q;
	logic [TIME_W-1:0]     earl_t_q;
	logic [IDX_W-1:0]      best_q;
	logic [COUNT_BITS-1:0] best_c_q;
	logic [TIME_W-1:0]     fin_q;
	logic                  dly_q;

	logic [TIME_W-1:0]     ft_d;
	logic [COUNT_BITS-1:0] cnt_d;
	logic [COUNT_BITS-1:0] cnt_n;
	logic [IDX_W-1:0]      pick_now;
	logic [IDX_W-1:0]      cnt_raddr;
	logic [START_W-1:0]    dur;
	logic [TIME_W:0]       sum;
	logic [TIME_W-1:0]     fin_now;

	always_comb begin
		ft_d      = ft_rv_q ? ft_rd_q : '0;
		cnt_d     = cnt_rv_q ? cnt_rd_q : '0;
		cnt_n     = (&cnt_d) ? cnt_d : cnt_d + COUNT_BITS'(1);
		pick_now  = found_q ? pick_q : earl_q;
		cnt_raddr = (uw.op == OP_PICK) ? pick_now : idx_q;
		dur       = (end_q > start_q) ? end_q - start_q : '0;
		sum       = {1'b0, earl_t_q} + (TIME_W+1)'(dur);
		if (found_q) begin
			fin_now = TIME_W'(end_q);
		end else if (sum[TIME_W]) begin
			fin_now = '1;
		end else begin
			fin_now = sum[TIME_W-1:0];
		end
	end

	// memory ports: registered reads, single write each
	always_ff @(posedge clk) begin
		ft_rd_q  <= ft_mem[idx_q];
		cnt_rd_q <= cnt_mem[cnt_raddr];
		if (uw.op == OP_PICK) begin
			ft_mem[pick_now] <= fin_now;
		end
		if (uw.op == OP_INC) begin
			cnt_mem[pick_q] <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_vld_q  <= '0;
			cnt_vld_q <= '0;
			rd_ft_q   <= 1'b0;
			rd_cnt_q  <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_ft_q  <= (uw.op == OP_SCAN);
			rd_cnt_q <= (uw.op == OP_BSCAN);
			if (uw.op == OP_LOAD && in_take) begin
				found_q <= 1'b0;
			end else if (rd_ft_q && !found_q && ft_d <= TIME_W'(start_q)) begin
				found_q <= 1'b1;
			end
			if (uw.op == OP_PICK) begin
				ft_vld_q[pick_now] <= 1'b1;
			end
			if (uw.op == OP_INC) begin
				cnt_vld_q[pick_q] <= 1'b1;
			end
			if (uw.op == OP_CLEAR) begin
				ft_vld_q  <= '0;
				cnt_vld_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ft_rv_q  <= ft_vld_q[idx_q];
		cnt_rv_q <= cnt_vld_q[cnt_raddr];
		rdidx_q  <= idx_q;
		if (uw.op == OP_LOAD && in_take) begin
			start_q <= start_time;
			end_q   <= end_time;
			last_q  <= last_meeting;
		end
		case (uw.op)
			OP_LOAD:  idx_q <= '0;
			OP_INC:   idx_q <= '0;
			OP_SCAN:  idx_q <= idx_q + IDX_W'(1);
			OP_BSCAN: idx_q <= idx_q + IDX_W'(1);
			default:  idx_q <= idx_q;
		endcase
		// first free room and earliest-free room, one entry per beat of read data
		if (rd_ft_q) begin
			if (!found_q && ft_d <= TIME_W'(start_q)) begin
				pick_q <= rdidx_q;
			end
			if (rdidx_q == '0 || ft_d < earl_t_q) begin
				earl_q   <= rdidx_q;
				earl_t_q <= ft_d;
			end
		end
		if (uw.op == OP_PICK) begin
			pick_q <= pick_now;
			fin_q  <= fin_now;
			dly_q  <= !found_q;
		end
		// most-booked room, strict greater keeps the lowest index
		if (rd_cnt_q && (rdidx_q == '0 || cnt_d > best_c_q)) begin
			best_q   <= rdidx_q;
			best_c_q <= cnt_d;
		end
	end

	assign scan_more        = (idx_q != last_idx);
	assign last_flag        = last_q;
	assign assigned_room    = ROOM_W'(pick_q);
	assign was_delayed      = dly_q;
	assign finish_time      = fin_q;
	assign most_booked_room = last_q ? ROOM_W'(best_q) : '0;

endmodule

// ----- rtl/earliest_free_room_assigner.sv -----
// Top level of the earliest-free room assigner: config, sequencer, datapath, output register.
// Per request: a scan of the n active rooms (n being the active room count, one room memory read
//   per cycle), then pick and count update; the last request of a batch also scans the booking
//   counts and clears the rooms. Throughput: one request in flight; the next input beat is taken
//   only after the previous result has entered the output register, which waits on a stalled sink.
// Reset (arst_n low, asynchronous): all rooms free at time zero with zero bookings,
//   rooms_in_use back to 16, no result pending. Batch end clears all rooms.
module earliest_free_room_assigner
	import efra_pkg::*;
#(
	parameter int ROOMS      = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// config: rooms_in_use
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	// request stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,   // [19:0] start_time, [39:20] end_time
	input  logic             s_tlast,   // last_meeting
	// result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,   // [6:0] assigned_room, [7] was_delayed,
	                                    // [55:8] finish_time, [62:56] most_booked_room, [63] zero
	output logic             m_tlast    // batch_done
);

	localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;

	logic [CFG_W-1:0]  rooms_q;
	logic [IDX_W-1:0]  last_idx;
	uword_t            uw;
	stat_t             stat;
	logic              scan_more;
	logic              last_flag;
	logic [ROOM_W-1:0] assigned_room;
	logic              was_delayed;
	logic [TIME_W-1:0] finish_time;
	logic [ROOM_W-1:0] most_booked_room;
	logic              emit;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;
	logic              m_tlast_q;

	// rooms_in_use register, reset 16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rooms_q <= CFG_W'(16);
		end else if (cfg_we) begin
			rooms_q <= cfg_wdata;
		end
	end

	// clamp to 1..ROOMS, kept as the index of the last active room
	always_comb begin
		if (rooms_q == '0) begin
			last_idx = '0;
		end else if (int'(rooms_q) > ROOMS) begin
			last_idx = IDX_W'(ROOMS - 1);
		end else begin
			last_idx = IDX_W'(rooms_q - CFG_W'(1));
		end
	end

	// output slot frees up in the same cycle the sink takes the beat
	assign stat.in_valid  = s_tvalid;
	assign stat.scan_more = scan_more;
	assign stat.last      = last_flag;
	assign stat.out_busy  = m_tvalid_q && !m_tready;

	assign s_tready = (uw.op == OP_LOAD);
	assign emit     = (uw.op == OP_EMIT) && !stat.out_busy;

	efra_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uw     (uw)
	);

	efra_dp #(
		.ROOMS      (ROOMS),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.uw               (uw),
		.in_take          (s_tvalid),
		.start_time       (s_tdata[19:0]),
		.end_time         (s_tdata[39:20]),
		.last_meeting     (s_tlast),
		.last_idx         (last_idx),
		.scan_more        (scan_more),
		.last_flag        (last_flag),
		.assigned_room    (assigned_room),
		.was_delayed      (was_delayed),
		.finish_time      (finish_time),
		.most_booked_room (most_booked_room)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {1'b0, most_booked_room, finish_time, was_delayed, assigned_room};
			m_tlast_q <= last_flag;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- rtl/efra_chk.sv -----
// Port-level checker for the room assigner, bound to the top level.
module efra_chk #(
	parameter int ROOMS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast
);

	// one request at a time: no second beat right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on back-to-back cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_room_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(m_tdata[6:0]) < ROOMS) && (int'(m_tdata[62:56]) < ROOMS))
		else $error("room index beyond built rooms");

	a_best_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[62:56] == 7'd0)
		else $error("most-booked room set outside batch end");

	// an on-time meeting ends at its own end time, which fits in 20 bits
	a_ontime_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[7] |-> m_tdata[55:28] == 28'd0)
		else $error("on-time finish beyond request range");

endmodule

bind earliest_free_room_assigner efra_chk #(
	.ROOMS (ROOMS)
) u_efra_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
